/* design/wmie_pkg.sv */
// wmie_pkg: shared constants, codes and controller/datapath command types
// for the word machine instruction executor. no dependencies.
package wmie_pkg;

   localparam int unsigned REG_COUNT_DEF      = 16;
   localparam int unsigned ADDR_REG_COUNT_DEF = 4;
   localparam int unsigned RAM_WORDS_DEF      = 1024;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned PC_W   = 12;
   localparam int unsigned CFG_W  = 10;
   localparam int unsigned OP_W   = 8;
   localparam int unsigned ST_W   = 4;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END   = 8'd1;

   localparam logic [OP_W-1:0] OP_LOADI  = 8'd0;
   localparam logic [OP_W-1:0] OP_LOADA  = 8'd1;
   localparam logic [OP_W-1:0] OP_LOADM  = 8'd2;
   localparam logic [OP_W-1:0] OP_STOREM = 8'd3;
   localparam logic [OP_W-1:0] OP_ADD    = 8'd4;
   localparam logic [OP_W-1:0] OP_SUB    = 8'd5;
   localparam logic [OP_W-1:0] OP_MUL    = 8'd6;
   localparam logic [OP_W-1:0] OP_DIV    = 8'd7;
   localparam logic [OP_W-1:0] OP_AND    = 8'd8;
   localparam logic [OP_W-1:0] OP_OR     = 8'd9;
   localparam logic [OP_W-1:0] OP_XOR    = 8'd10;
   localparam logic [OP_W-1:0] OP_JMP    = 8'd11;
   localparam logic [OP_W-1:0] OP_JZ     = 8'd12;
   localparam logic [OP_W-1:0] OP_JNZ    = 8'd13;
   localparam logic [OP_W-1:0] OP_CMP    = 8'd14;
   localparam logic [OP_W-1:0] OP_HALT   = 8'd15;

   localparam logic [WORD_W-1:0] MODE_REG = 32'd0;
   localparam logic [WORD_W-1:0] MODE_LIT = 32'd1;

   localparam logic [ST_W-1:0] ST_OK       = 4'd0;
   localparam logic [ST_W-1:0] ST_HALT     = 4'd1;
   localparam logic [ST_W-1:0] ST_END      = 4'd2;
   localparam logic [ST_W-1:0] ST_BAD_OP   = 4'd3;
   localparam logic [ST_W-1:0] ST_BAD_REG  = 4'd4;
   localparam logic [ST_W-1:0] ST_BAD_AREG = 4'd5;
   localparam logic [ST_W-1:0] ST_BAD_ADDR = 4'd6;
   localparam logic [ST_W-1:0] ST_BAD_MODE = 4'd7;
   localparam logic [ST_W-1:0] ST_DIV_ZERO = 4'd8;
   localparam logic [ST_W-1:0] ST_STOPPED  = 4'd9;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture the input beat
      logic read_ops;   // register operand reads
      logic check;      // run checks, resolve address
      logic mem_rd;     // issue data memory read
      logic div_start;
      logic mul_start;
      logic commit;     // compute result, update state, load response
      logic clear_step; // clearing pass step
   } ctl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic need_mul;
      logic need_mem;
      logic div_done;
      logic clear_done;
   } dp_stat_type;

endpackage

/* design/wmie_if.sv */
// wmie_if: valid/ready channel interfaces for the instruction, result and
// register write channels. depends on wmie_pkg.
interface wmie_req_if;
   logic                        valid;
   logic                        ready;
   logic [wmie_pkg::OP_W-1:0]   op;
   logic [wmie_pkg::WORD_W-1:0] first_word;
   logic [wmie_pkg::WORD_W-1:0] second_word;
   logic [wmie_pkg::WORD_W-1:0] third_word;
   modport source (output valid, op, first_word, second_word, third_word, input ready);
   modport sink (input valid, op, first_word, second_word, third_word, output ready);
endinterface

interface wmie_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wmie_pkg::ST_W-1:0]   status;
   logic [wmie_pkg::PC_W-1:0]   next_pc;
   logic                        zero_out;
   logic                        negative_out;
   logic [wmie_pkg::WORD_W-1:0] written_value;
   modport source (output valid, status, next_pc, zero_out, negative_out, written_value,
                   input ready);
   modport sink (input valid, status, next_pc, zero_out, negative_out, written_value,
                 output ready);
endinterface

interface wmie_csr_if;
   logic                           valid;
   logic                           ready;
   logic [wmie_pkg::CSR_IDX_W-1:0] index;
   logic [wmie_pkg::WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/wmie_divider.sv */
// wmie_divider: radix-2 restoring unsigned divider, one quotient bit a cycle.
// depends on wmie_pkg.
module wmie_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wmie_pkg::WORD_W-1:0] dividend,
   input  logic [wmie_pkg::WORD_W-1:0] divisor,
   output logic                        done,
   output logic [wmie_pkg::WORD_W-1:0] quotient
);
   localparam int unsigned W  = wmie_pkg::WORD_W;
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* design/wmie_datapath.sv */
// wmie_datapath: register files, data memory, checks, alu, divider and
// result register. depends on wmie_pkg and wmie_divider.
module wmie_datapath #(
   parameter int unsigned REG_COUNT      = wmie_pkg::REG_COUNT_DEF,
   parameter int unsigned ADDR_REG_COUNT = wmie_pkg::ADDR_REG_COUNT_DEF,
   parameter int unsigned RAM_WORDS      = wmie_pkg::RAM_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wmie_pkg::ctl_cmd_type         cmd,
   output wmie_pkg::dp_stat_type         stat,
   input  logic [wmie_pkg::OP_W-1:0]     in_op,
   input  logic [wmie_pkg::WORD_W-1:0]   in_d,
   input  logic [wmie_pkg::WORD_W-1:0]   in_m,
   input  logic [wmie_pkg::WORD_W-1:0]   in_s,
   input  logic                          csr_we,
   input  logic [wmie_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [wmie_pkg::WORD_W-1:0]   csr_wdata,
   output logic [wmie_pkg::ST_W-1:0]     rsp_status,
   output logic [wmie_pkg::PC_W-1:0]     rsp_pc,
   output logic                          rsp_zero,
   output logic                          rsp_neg,
   output logic [wmie_pkg::WORD_W-1:0]   rsp_wv
);
   localparam int unsigned W   = wmie_pkg::WORD_W;
   localparam int unsigned RW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int unsigned ARW = (ADDR_REG_COUNT > 1) ? $clog2(ADDR_REG_COUNT) : 1;
   localparam int unsigned MW  = $clog2(RAM_WORDS);
   localparam int unsigned PW  = wmie_pkg::PC_W;
   localparam int unsigned CFW = wmie_pkg::CFG_W;

   logic [W-1:0]  reg_file_ff [REG_COUNT];
   logic [MW-1:0] areg_ff     [ADDR_REG_COUNT];
   logic [W-1:0]  mem [RAM_WORDS];

   logic [wmie_pkg::OP_W-1:0] op_ff;
   logic [W-1:0] d_ff, m_ff, s_ff;
   logic [W-1:0] rd_ff, src_ff, rm_ff, mem_q_ff, prod_ff;
   logic [MW-1:0] addr_ff;
   logic [wmie_pkg::ST_W-1:0] err_ff;

   logic [CFW-1:0] end_ff;
   logic [PW-1:0]  pc_ff;
   logic           zero_ff, neg_ff, stop_ff;
   logic [MW-1:0]  clr_ff;
   logic           clr_done_ff;

   logic [wmie_pkg::ST_W-1:0] rst_ff;
   logic [PW-1:0] rpc_ff;
   logic rz_ff, rn_ff;
   logic [W-1:0] rwv_ff;

   logic div_done;
   logic [W-1:0] div_q;

   logic is_alu;
   assign is_alu = (op_ff >= wmie_pkg::OP_ADD) && (op_ff <= wmie_pkg::OP_XOR);

   wmie_divider u_div (
      .clock, .reset,
      .start(cmd.div_start), .dividend(rd_ff), .divisor(src_ff),
      .done(div_done), .quotient(div_q)
   );

   // operand checks, in the order the machine defines
   logic [wmie_pkg::ST_W-1:0] err_c;
   logic [W-1:0] raw_addr;
   logic [W-1:0] aop;
   always_comb begin
      err_c    = wmie_pkg::ST_OK;
      raw_addr = '0;
      aop      = (op_ff == wmie_pkg::OP_STOREM) ? d_ff : s_ff;
      if (m_ff == wmie_pkg::MODE_LIT) raw_addr = aop;
      else if (aop < W'(ADDR_REG_COUNT)) raw_addr = W'(areg_ff[aop[ARW-1:0]]);
      case (op_ff)
         wmie_pkg::OP_LOADI: if (d_ff >= W'(REG_COUNT)) err_c = wmie_pkg::ST_BAD_REG;
         wmie_pkg::OP_LOADA: begin
            if (d_ff >= W'(ADDR_REG_COUNT)) err_c = wmie_pkg::ST_BAD_AREG;
            else if (m_ff >= W'(RAM_WORDS)) err_c = wmie_pkg::ST_BAD_ADDR;
         end
         wmie_pkg::OP_LOADM, wmie_pkg::OP_STOREM: begin
            if (((op_ff == wmie_pkg::OP_LOADM) ? d_ff : s_ff) >= W'(REG_COUNT))
               err_c = wmie_pkg::ST_BAD_REG;
            else if (m_ff != wmie_pkg::MODE_LIT && aop >= W'(ADDR_REG_COUNT))
               err_c = wmie_pkg::ST_BAD_AREG;
            else if (raw_addr >= W'(RAM_WORDS)) err_c = wmie_pkg::ST_BAD_ADDR;
         end
         wmie_pkg::OP_JMP, wmie_pkg::OP_JZ, wmie_pkg::OP_JNZ:
            if (d_ff >= W'(RAM_WORDS)) err_c = wmie_pkg::ST_BAD_ADDR;
         wmie_pkg::OP_CMP:
            if (d_ff >= W'(REG_COUNT) || m_ff >= W'(REG_COUNT)) err_c = wmie_pkg::ST_BAD_REG;
         wmie_pkg::OP_HALT: err_c = wmie_pkg::ST_HALT;
         default: begin
            if (is_alu) begin
               if (d_ff >= W'(REG_COUNT)) err_c = wmie_pkg::ST_BAD_REG;
               else if (m_ff == wmie_pkg::MODE_REG && s_ff >= W'(REG_COUNT))
                  err_c = wmie_pkg::ST_BAD_REG;
               else if (m_ff != wmie_pkg::MODE_REG && m_ff != wmie_pkg::MODE_LIT)
                  err_c = wmie_pkg::ST_BAD_MODE;
               else if (op_ff == wmie_pkg::OP_DIV && m_ff == wmie_pkg::MODE_LIT
                        && s_ff == '0)
                  err_c = wmie_pkg::ST_DIV_ZERO;
               else if (op_ff == wmie_pkg::OP_DIV && m_ff == wmie_pkg::MODE_REG
                        && src_ff == '0)
                  err_c = wmie_pkg::ST_DIV_ZERO;
            end else begin
               err_c = wmie_pkg::ST_BAD_OP;
            end
         end
      endcase
   end

   assign stat.need_div   = (op_ff == wmie_pkg::OP_DIV);
   assign stat.need_mul   = (op_ff == wmie_pkg::OP_MUL);
   assign stat.need_mem   = (op_ff == wmie_pkg::OP_LOADM);
   assign stat.div_done   = div_done;
   assign stat.clear_done = clr_done_ff;

   // result and next state
   logic [W-1:0] res_c, diff_c;
   always_comb begin
      diff_c = rd_ff - rm_ff;
      case (op_ff)
         wmie_pkg::OP_ADD: res_c = rd_ff + src_ff;
         wmie_pkg::OP_SUB: res_c = rd_ff - src_ff;
         wmie_pkg::OP_MUL: res_c = prod_ff;
         wmie_pkg::OP_DIV: res_c = div_q;
         wmie_pkg::OP_AND: res_c = rd_ff & src_ff;
         wmie_pkg::OP_OR:  res_c = rd_ff | src_ff;
         wmie_pkg::OP_XOR: res_c = rd_ff ^ src_ff;
         wmie_pkg::OP_LOADI, wmie_pkg::OP_LOADA: res_c = m_ff;
         wmie_pkg::OP_LOADM: res_c = mem_q_ff;
         wmie_pkg::OP_STOREM: res_c = src_ff;
         default: res_c = '0;
      endcase
   end

   logic [PW-1:0] pc_in;
   logic z_in, n_in, stop_in;
   logic [wmie_pkg::ST_W-1:0] st_in;
   logic [W-1:0] wv_in;
   logic reg_we, areg_we, mem_we;
   always_comb begin
      pc_in = pc_ff; z_in = zero_ff; n_in = neg_ff; stop_in = stop_ff;
      st_in = wmie_pkg::ST_OK; wv_in = '0;
      reg_we = 1'b0; areg_we = 1'b0; mem_we = 1'b0;
      if (stop_ff) begin
         st_in = wmie_pkg::ST_STOPPED;
      end else if (pc_ff == PW'(end_ff)) begin
         st_in = wmie_pkg::ST_END; stop_in = 1'b1;
      end else if (err_ff != wmie_pkg::ST_OK) begin
         st_in = err_ff; stop_in = 1'b1;
      end else begin
         case (op_ff)
            wmie_pkg::OP_LOADI: begin
               reg_we = 1'b1; z_in = (res_c == '0); wv_in = res_c; pc_in = pc_ff + PW'(3);
            end
            wmie_pkg::OP_LOADA: begin
               areg_we = 1'b1; wv_in = res_c; pc_in = pc_ff + PW'(3);
            end
            wmie_pkg::OP_STOREM: begin
               mem_we = 1'b1; wv_in = res_c; pc_in = pc_ff + PW'(4);
            end
            wmie_pkg::OP_JMP: pc_in = d_ff[PW-1:0];
            wmie_pkg::OP_JZ:  pc_in = zero_ff ? d_ff[PW-1:0] : pc_ff + PW'(2);
            wmie_pkg::OP_JNZ: pc_in = zero_ff ? pc_ff + PW'(2) : d_ff[PW-1:0];
            wmie_pkg::OP_CMP: begin
               z_in = (diff_c == '0); n_in = diff_c[W-1]; pc_in = pc_ff + PW'(3);
            end
            default: begin
               // loadm and arithmetic write a general register
               reg_we = 1'b1; z_in = (res_c == '0); wv_in = res_c; pc_in = pc_ff + PW'(4);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op; d_ff <= in_d; m_ff <= in_m; s_ff <= in_s;
      end
      if (cmd.read_ops) begin
         rd_ff <= reg_file_ff[d_ff[RW-1:0]];
         rm_ff <= reg_file_ff[m_ff[RW-1:0]];
         if (op_ff == wmie_pkg::OP_STOREM || m_ff == wmie_pkg::MODE_REG)
            src_ff <= reg_file_ff[s_ff[RW-1:0]];
         else
            src_ff <= s_ff;
      end
      if (cmd.check) begin
         err_ff  <= err_c;
         addr_ff <= raw_addr[MW-1:0];
      end
      if (cmd.mul_start) prod_ff <= rd_ff * src_ff;
      if (cmd.mem_rd) mem_q_ff <= mem[addr_ff];
      if (cmd.commit) begin
         rst_ff <= st_in; rpc_ff <= pc_in; rz_ff <= z_in; rn_ff <= n_in; rwv_ff <= wv_in;
      end
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (cmd.commit && mem_we) mem[addr_ff] <= res_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_ff <= '1;
         pc_ff <= '0; zero_ff <= 1'b0; neg_ff <= 1'b0; stop_ff <= 1'b0;
         clr_ff <= '0; clr_done_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) reg_file_ff[i] <= '0;
         for (int i = 0; i < ADDR_REG_COUNT; i++) areg_ff[i] <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == MW'(RAM_WORDS - 1)) clr_done_ff <= 1'b1;
         end
         if (cmd.commit) begin
            zero_ff <= z_in; neg_ff <= n_in;
            if (reg_we) reg_file_ff[d_ff[RW-1:0]] <= res_c;
            if (areg_we) areg_ff[d_ff[ARW-1:0]] <= res_c[MW-1:0];
         end
         // a restart reloads the pc and clears the stop flag
         if (csr_we && csr_idx == wmie_pkg::CSR_START) begin
            pc_ff   <= PW'(csr_wdata[CFW-1:0]);
            stop_ff <= 1'b0;
         end else if (cmd.commit) begin
            pc_ff <= pc_in; stop_ff <= stop_in;
         end
         if (csr_we && csr_idx == wmie_pkg::CSR_END) begin
            end_ff <= csr_wdata[CFW-1:0];
         end
      end
   end

   assign rsp_status = rst_ff;
   assign rsp_pc     = rpc_ff;
   assign rsp_zero   = rz_ff;
   assign rsp_neg    = rn_ff;
   assign rsp_wv     = rwv_ff;
endmodule

/* design/wmie_control.sv */
// wmie_control: sequencer for the memory clear after reset, fetch of operands,
// checks, memory read, multiply, divide, commit and response handshake. depends on wmie_pkg.
module wmie_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wmie_pkg::ctl_cmd_type cmd,
   input  wmie_pkg::dp_stat_type stat
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CHECK, S_EXEC, S_DIV, S_COMMIT, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               cmd.clear_step = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: if (req_valid && !rsp_valid_ff) begin
            cmd.load = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.read_ops = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.mem_rd    = stat.need_mem;
            cmd.mul_start = stat.need_mul;
            cmd.div_start = stat.need_div;
            state_in = stat.need_div ? S_DIV : S_COMMIT;
         end
         S_DIV: if (stat.div_done) begin
            cmd.commit = 1'b1;
            state_in = S_RESP;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule

/* design/word_machine_instruction_executor.sv */
// word_machine_instruction_executor: top level of the word machine
// instruction executor. depends on wmie_pkg, wmie_if, wmie_control, wmie_datapath.
//
// usage: each beat on req carries one decoded instruction (opcode and three
// operand words); exactly one beat comes back on rsp with status, next pc,
// flags and the written value. csr writes the start pc (index 0, also
// restarts the machine) and the finish pc (index 1); write only while idle.
// each instruction steps through read, check, execute, commit and response;
// div also waits in a divide state until the radix-2 divider is done.
// one instruction at a time: the next beat is taken once the previous
// result has been taken.
// reset: registers, address registers, flags and pc are cleared at once;
// the data memory is then swept to zero, one word a cycle, during which
// req is not ready. csr stays ready. a stalled rsp holds its beat and req
// stays not ready until it drains.
module word_machine_instruction_executor #(
   parameter int unsigned REG_COUNT      = wmie_pkg::REG_COUNT_DEF,
   parameter int unsigned ADDR_REG_COUNT = wmie_pkg::ADDR_REG_COUNT_DEF,
   parameter int unsigned RAM_WORDS      = wmie_pkg::RAM_WORDS_DEF
) (
   input logic        clock,
   input logic        reset,
   wmie_req_if.sink   req,
   wmie_rsp_if.source rsp,
   wmie_csr_if.sink   csr
);
   wmie_pkg::ctl_cmd_type cmd;
   wmie_pkg::dp_stat_type stat;

   assign csr.ready = 1'b1;

   wmie_control u_ctl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .stat
   );

   wmie_datapath #(
      .REG_COUNT(REG_COUNT), .ADDR_REG_COUNT(ADDR_REG_COUNT), .RAM_WORDS(RAM_WORDS)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .in_op(req.op), .in_d(req.first_word), .in_m(req.second_word),
      .in_s(req.third_word),
      .csr_we(csr.valid), .csr_idx(csr.index), .csr_wdata(csr.data),
      .rsp_status(rsp.status), .rsp_pc(rsp.next_pc), .rsp_zero(rsp.zero_out),
      .rsp_neg(rsp.negative_out), .rsp_wv(rsp.written_value)
   );
endmodule

/* design/wmie_checker.sv */
// wmie_checker: port-level checks on the executor, bound to the top level.
// depends on wmie_pkg and word_machine_instruction_executor.
module wmie_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wmie_pkg::ST_W-1:0]   rsp_status,
   input logic [wmie_pkg::WORD_W-1:0] rsp_written_value
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp beat dropped while stalled");

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req taken while result pending");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= wmie_pkg::ST_STOPPED)
      else $error("status out of range");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != wmie_pkg::ST_OK |-> rsp_written_value == '0)
      else $error("written value on failed instruction");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("executor not busy after accept");
endmodule

bind word_machine_instruction_executor wmie_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_written_value(rsp.written_value)
);
